// ----- design/priority_job_slot_queue_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority job slot queue
// Property wrappers clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_JOB_SLOT_QUEUE_CORE_ASSERT_SVH
`define PRIORITY_JOB_SLOT_QUEUE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PJSQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PJSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pjsq_pkg.sv -----
// ----------------------------------------------------------------------------
// pjsq_pkg
// Shared sizes, request codes, sequencer states and slot record types.
// ----------------------------------------------------------------------------
package pjsq_pkg;

  // Table depth and derived index widths
  localparam int QUEUE_SLOTS = 8;
  localparam int SLOT_W      = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

  // Field widths
  localparam int REQ_W  = 3;
  localparam int KIND_W = 3;
  localparam int PRIO_W = 2;
  localparam int CTX_W  = 32;
  localparam int ARG_W  = 32;
  localparam int SEQ_W  = 32;
  localparam int DROP_W = 4;

  localparam logic [CNT_W-1:0]  SCAN_END = CNT_W'(QUEUE_SLOTS);
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQUEUE     = 3'd0,
    REQ_POP         = 3'd1,
    REQ_SET_CONTEXT = 3'd2,
    REQ_CANCEL_KIND = 3'd3,
    REQ_CANCEL_ALL  = 3'd4,
    REQ_FINISH      = 3'd5
  } req_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // One queued job as held in the slot memory
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PRIO_W-1:0] prio;
    logic [SEQ_W-1:0]  seq;
    logic [CTX_W-1:0]  ctx;
    logic [ARG_W-1:0]  arg;
  } slot_t;

  // Slot memory write and read requests
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } mem_rd_t;

endpackage

// ----- design/pjsq_slot_mem.sv -----
// ----------------------------------------------------------------------------
// pjsq_slot_mem
// Slot payload store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pjsq_slot_mem import pjsq_pkg::*; (
  input  logic    clk,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output slot_t   rd_data
);

  slot_t mem [QUEUE_SLOTS];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ----- design/priority_job_slot_queue_core.sv -----
// ----------------------------------------------------------------------------
// priority_job_slot_queue_core
// Slot table of pending jobs with priority pop, context and kind cancels.
// ----------------------------------------------------------------------------
// Each request is handled alone. After the input transfer a sequencer walks
// the slot memory one entry per cycle through a single compare unit, the read
// data being registered, applies the outcome in the commit state and moves the
// result to the output register in the done state, once the output register is
// free; then the input is ready again. A stalled output holds the sequencer
// only when a second result is done before the first is taken. The single
// slot memory read port sets the pace of the walk. No clearing pass follows
// reset.
module priority_job_slot_queue_core import pjsq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [KIND_W-1:0] job_kind,
  input  logic [PRIO_W-1:0] job_priority,
  input  logic [CTX_W-1:0]  job_context,
  input  logic [ARG_W-1:0]  job_arg,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              accepted,
  output logic [KIND_W-1:0] out_kind,
  output logic [PRIO_W-1:0] out_priority,
  output logic [CTX_W-1:0]  out_context,
  output logic [ARG_W-1:0]  out_arg,
  output logic              stale,
  output logic [DROP_W-1:0] dropped_count,
  output logic              abort_requested,
  output logic              busy_res
);

  typedef struct packed {
    logic              accepted;
    logic [KIND_W-1:0] kind;
    logic [PRIO_W-1:0] prio;
    logic [CTX_W-1:0]  ctx;
    logic [ARG_W-1:0]  arg;
    logic              stale;
    logic [DROP_W-1:0] dropped;
    logic              abort;
    logic              busy;
  } res_t;

  state_t state, state_next;

  // Latched request
  logic [REQ_W-1:0]  req_q;
  logic [KIND_W-1:0] kind_q;
  logic [PRIO_W-1:0] prio_q;
  logic [CTX_W-1:0]  ctx_q;
  logic [ARG_W-1:0]  arg_q;

  // Scan control
  logic [CNT_W-1:0]  cnt;
  logic              eval_ok;
  logic [SLOT_W-1:0] eval_idx;
  logic              found;
  logic [SLOT_W-1:0] best_idx;
  slot_t             best;
  logic [DROP_W-1:0] drop_cnt;

  // Table and flight state
  logic [QUEUE_SLOTS-1:0] slot_valid;
  logic [SEQ_W-1:0]       next_seq;
  logic [CTX_W-1:0]       cur_ctx;
  logic                   fl_valid, fl_valid_next;
  logic                   fl_abort, fl_abort_next;
  logic [CTX_W-1:0]       fl_ctx, fl_ctx_next;
  logic [KIND_W-1:0]      fl_kind, fl_kind_next;

  // Results
  res_t res, res_next, out_res;

  // Memory ports
  mem_wr_t wr;
  mem_rd_t rd;
  slot_t   rd_data;

  // Control strobes
  logic in_xfer, out_free, out_load, scan_eval, commit;
  logic commit_enq, commit_pop;
  logic ev_valid, ev_better, ev_take, ev_drop, stale_c;

  pjsq_slot_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == SCAN_END && eval_ok) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    rd.en     = 1'b0;
    rd.addr   = cnt[SLOT_W-1:0];
    scan_eval = 1'b0;
    commit    = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        rd.en     = (cnt != SCAN_END);
        scan_eval = eval_ok;
      end
      ST_COMMIT: begin
        commit = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Shared compare unit: judges the slot whose data arrived this cycle
  always_comb begin
    ev_valid  = slot_valid[eval_idx];
    ev_better = (rd_data.prio > best.prio) ||
                ((rd_data.prio == best.prio) && (rd_data.seq < best.seq));
    ev_take   = 1'b0;
    ev_drop   = 1'b0;
    case (req_q)
      REQ_ENQUEUE:     ev_take = !ev_valid && !found;
      REQ_POP:         ev_take = ev_valid && (!found || ev_better);
      REQ_SET_CONTEXT: ev_drop = ev_valid && (rd_data.ctx != ctx_q);
      REQ_CANCEL_KIND: ev_drop = ev_valid && (rd_data.kind == kind_q);
      REQ_CANCEL_ALL:  ev_drop = ev_valid;
      default: ;
    endcase
  end

  assign stale_c    = (cur_ctx != '0) && (best.ctx != cur_ctx);
  assign commit_enq = commit && (req_q == REQ_ENQUEUE) && (kind_q != '0) && found;
  assign commit_pop = commit && (req_q == REQ_POP) && found;

  // Slot write on enqueue
  always_comb begin
    wr.en        = commit_enq;
    wr.addr      = best_idx;
    wr.data.kind = kind_q;
    wr.data.prio = prio_q;
    wr.data.seq  = next_seq;
    wr.data.ctx  = ctx_q;
    wr.data.arg  = arg_q;
  end

  // Flight record after the request
  always_comb begin
    fl_valid_next = fl_valid;
    fl_abort_next = fl_abort;
    fl_ctx_next   = fl_ctx;
    fl_kind_next  = fl_kind;
    case (req_q)
      REQ_POP: begin
        if (found && !stale_c) begin
          fl_valid_next = 1'b1;
          fl_abort_next = 1'b0;
          fl_ctx_next   = best.ctx;
          fl_kind_next  = best.kind;
        end
      end
      REQ_SET_CONTEXT: if (fl_valid && (fl_ctx != ctx_q)) fl_abort_next = 1'b1;
      REQ_CANCEL_KIND: if (fl_valid && (fl_kind == kind_q)) fl_abort_next = 1'b1;
      REQ_CANCEL_ALL:  if (fl_valid) fl_abort_next = 1'b1;
      REQ_FINISH: begin
        fl_valid_next = 1'b0;
        fl_abort_next = 1'b0;
        fl_ctx_next   = '0;
        fl_kind_next  = '0;
      end
      default: ;
    endcase
  end

  // Result of the request
  always_comb begin
    res_next       = '0;
    res_next.abort = fl_abort_next;
    res_next.busy  = fl_valid_next;
    case (req_q)
      REQ_ENQUEUE: res_next.accepted = (kind_q != '0) && found;
      REQ_POP: begin
        if (found) begin
          res_next.accepted = 1'b1;
          res_next.kind     = best.kind;
          res_next.prio     = best.prio;
          res_next.ctx      = best.ctx;
          res_next.arg      = best.arg;
          res_next.stale    = stale_c;
        end
      end
      REQ_SET_CONTEXT, REQ_CANCEL_KIND, REQ_CANCEL_ALL: res_next.dropped = drop_cnt;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      eval_ok    <= 1'b0;
      found      <= 1'b0;
      drop_cnt   <= '0;
      slot_valid <= '0;
      next_seq   <= '0;
      cur_ctx    <= '0;
      fl_valid   <= 1'b0;
      fl_abort   <= 1'b0;
      fl_ctx     <= '0;
      fl_kind    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // scan counter and drop tally
      if (in_xfer) begin
        cnt      <= '0;
        eval_ok  <= 1'b0;
        found    <= 1'b0;
        drop_cnt <= '0;
      end else if (state == ST_SCAN) begin
        if (rd.en) begin
          cnt     <= cnt + 1'b1;
          eval_ok <= 1'b1;
        end else begin
          eval_ok <= 1'b0;
        end
        if (scan_eval && ev_take) found <= 1'b1;
        if (scan_eval && ev_drop && (drop_cnt != DROP_MAX)) drop_cnt <= drop_cnt + 1'b1;
      end
      // slot occupancy
      if (scan_eval && ev_drop) slot_valid[eval_idx] <= 1'b0;
      if (commit_enq) slot_valid[best_idx] <= 1'b1;
      if (commit_pop) slot_valid[best_idx] <= 1'b0;
      if (commit_enq) next_seq <= next_seq + 1'b1;
      if (commit && (req_q == REQ_SET_CONTEXT)) cur_ctx <= ctx_q;
      // flight record
      if (commit) begin
        fl_valid <= fl_valid_next;
        fl_abort <= fl_abort_next;
        fl_ctx   <= fl_ctx_next;
        fl_kind  <= fl_kind_next;
      end
      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_q  <= req_type;
      kind_q <= job_kind;
      prio_q <= job_priority;
      ctx_q  <= job_context;
      arg_q  <= job_arg;
    end
    if (rd.en) eval_idx <= cnt[SLOT_W-1:0];
    if (scan_eval && ev_take) begin
      best_idx <= eval_idx;
      best     <= rd_data;
    end
    if (commit) res <= res_next;
    if (out_load) out_res <= res;
  end

  assign accepted        = out_res.accepted;
  assign out_kind        = out_res.kind;
  assign out_priority    = out_res.prio;
  assign out_context     = out_res.ctx;
  assign out_arg         = out_res.arg;
  assign stale           = out_res.stale;
  assign dropped_count   = out_res.dropped;
  assign abort_requested = out_res.abort;
  assign busy_res        = out_res.busy;

`include "priority_job_slot_queue_core_assert.svh"

  `PJSQ_ASSERT_SAME(a_kind_needs_accept, clk, rst, out_valid && (out_kind != '0), accepted, "popped kind without accept")
  `PJSQ_ASSERT_SAME(a_stale_needs_accept, clk, rst, out_valid && stale, accepted, "stale flag without a popped job")
  `PJSQ_ASSERT_SAME(a_drop_not_accept, clk, rst, out_valid && (dropped_count != '0), !accepted, "drop count on enqueue or pop")
  `PJSQ_ASSERT_SAME(a_abort_needs_flight, clk, rst, fl_abort, fl_valid, "abort set with nothing in flight")
  `PJSQ_ASSERT_NEXT(a_busy_after_xfer, clk, rst, in_valid && in_ready, !in_ready, "input ready right after a transfer")

endmodule
